// File: design/dttf_pkg.sv
// ----------------------------------------------------------------------------
// dttf_pkg
// Shared constants, the field record type and the power-of-five table builder
// for the decimal text to binary float converter.
// ----------------------------------------------------------------------------
package dttf_pkg;

	localparam int CNT_BITS_DEF = 32;
	localparam int POW5_ENTRIES = 651;
	localparam int POW5_MIN_Q = -342;
	localparam int POW5_IDX_BITS = 10;
	localparam int Q_BITS = 12;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_AMBIGUOUS = 2'd2;

	// double format
	localparam logic [5:0] F64_MANT = 6'd52;
	localparam logic [5:0] F64_SIGN = 6'd63;
	localparam logic [6:0] F64_SHBASE = 7'd9;
	localparam logic [63:0] F64_MASK = 64'h0000_0000_0000_01FF;
	localparam logic signed [12:0] F64_MIN_EXP = -13'sd1023;
	localparam logic [11:0] F64_INF = 12'h7FF;
	localparam logic signed [Q_BITS-1:0] F64_SMALL10 = -12'sd342;
	localparam logic signed [Q_BITS-1:0] F64_LARGE10 = 12'sd308;
	localparam logic signed [Q_BITS-1:0] F64_RTE_LO = -12'sd4;
	localparam logic signed [Q_BITS-1:0] F64_RTE_HI = 12'sd23;

	// single format
	localparam logic [5:0] F32_MANT = 6'd23;
	localparam logic [5:0] F32_SIGN = 6'd31;
	localparam logic [6:0] F32_SHBASE = 7'd38;
	localparam logic [63:0] F32_MASK = 64'h0000_003F_FFFF_FFFF;
	localparam logic signed [12:0] F32_MIN_EXP = -13'sd127;
	localparam logic [11:0] F32_INF = 12'h0FF;
	localparam logic signed [Q_BITS-1:0] F32_SMALL10 = -12'sd64;
	localparam logic signed [Q_BITS-1:0] F32_LARGE10 = 12'sd38;
	localparam logic signed [Q_BITS-1:0] F32_RTE_LO = -12'sd17;
	localparam logic signed [Q_BITS-1:0] F32_RTE_HI = 12'sd10;

	typedef struct packed {
		logic ok;
		logic neg;
		logic too;
		logic [63:0] w;
		logic signed [Q_BITS-1:0] q;
	} dttf_rec_t;

	typedef logic [127:0] pow5_rom_t [0:POW5_ENTRIES-1];

	function automatic int dttf_msb(input logic [2047:0] v);
		int t;
		t = 0;
		for (int i = 0; i < 2048; i++) begin
			if (v[i]) begin
				t = i;
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] dttf_top128(input logic [2047:0] v);
		int t;
		logic [2047:0] s;
		t = dttf_msb(v);
		s = v << (2047 - t);
		return s[2047:1920];
	endfunction

	// top 128 bits of 5^q, and of a rounded-up reciprocal for negative q
	function automatic pow5_rom_t dttf_pow5_table();
		pow5_rom_t r;
		logic [2047:0] pw;
		logic [2047:0] d;
		logic [2047:0] rem;
		logic [2047:0] quo;
		int z;
		int b;
		pw = 2048'd1;
		for (int q = 0; q <= 308; q++) begin
			r[q - POW5_MIN_Q] = dttf_top128(pw);
			pw = pw + (pw << 2);
		end
		d = 2048'd1;
		for (int k = 1; k <= -POW5_MIN_Q; k++) begin
			d = d + (d << 2);
			z = dttf_msb(d) + 1;
			b = (k <= 27) ? z + 127 : 2 * z + 128;
			rem = '0;
			quo = '0;
			for (int i = b; i >= 0; i--) begin
				rem = rem << 1;
				if (i == b) begin
					rem[0] = 1'b1;
				end
				if (rem >= d) begin
					rem = rem - d;
					quo[i] = 1'b1;
				end
			end
			quo = quo + 2048'd1;
			r[-k - POW5_MIN_Q] = dttf_top128(quo);
		end
		return r;
	endfunction

endpackage

// File: design/dttf_scan.sv
// ----------------------------------------------------------------------------
// dttf_scan
// Byte scanner, one byte per cycle while in_ready is high: parses sign, digits,
// fraction and exponent and hands on each record (mantissa, decimal exponent).
// ----------------------------------------------------------------------------
module dttf_scan #(
	parameter int CNT_BITS = dttf_pkg::CNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          char_code,
	input  logic                has_char,
	input  logic                last_char,
	output logic                rec_valid,
	input  logic                rec_ready,
	output dttf_pkg::dttf_rec_t rec
);
	import dttf_pkg::*;

	localparam int EXP_BITS = (CNT_BITS < 32) ? CNT_BITS : 32;

	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_SIGN = 3'd1;
	localparam logic [2:0] PH_INT = 3'd2;
	localparam logic [2:0] PH_FRAC = 3'd3;
	localparam logic [2:0] PH_EXP = 3'd4;
	localparam logic [2:0] PH_EXPSIGN = 3'd5;
	localparam logic [2:0] PH_EXPDIG = 3'd6;
	localparam logic [2:0] PH_BAD = 3'd7;

	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_E_UP = 8'h45;
	localparam logic [7:0] CH_E_LO = 8'h65;

	localparam logic [63:0] TRUNC_LIMIT = 64'd1000000000000000000;
	localparam logic [35:0] EXP_LIMIT = 36'h010000000;
	localparam logic [15:0] SIG_MAX = 16'hFFFF;
	localparam logic [15:0] SIG_KEEP = 16'd19;
	localparam logic signed [CNT_BITS-1:0] SH_MAX = {1'b0, {(CNT_BITS-1){1'b1}}};
	localparam logic signed [CNT_BITS-1:0] SH_LOW = {1'b1, {(CNT_BITS-2){1'b0}}, 1'b1};
	localparam logic signed [65:0] LIM_POS = 66'sh01000000000000000;
	localparam logic signed [65:0] LIM_NEG = -66'sh01000000000000000;
	localparam logic signed [65:0] Q_HI = 66'sd2047;
	localparam logic signed [65:0] Q_LO = -66'sd2048;

	logic [2:0] phase_q, phase_n;
	logic neg_q, neg_n;
	logic [63:0] full_q, full_n;
	logic [63:0] trunc_q, trunc_n;
	logic [15:0] sig_q, sig_n;
	logic [CNT_BITS-1:0] dcnt_q, dcnt_n;
	logic [CNT_BITS-1:0] fcnt_q, fcnt_n;
	logic signed [CNT_BITS-1:0] shift_q, shift_n;
	logic [EXP_BITS-1:0] exp_q, exp_n;
	logic eneg_q, eneg_n;

	logic fin_v_s1, fin_ok_s1, fin_neg_s1, fin_too_s1, fin_eneg_s1;
	logic [63:0] fin_w_s1;
	logic [EXP_BITS-1:0] fin_exp_s1;
	logic [CNT_BITS-1:0] fin_frac_s1;
	logic signed [CNT_BITS-1:0] fin_shift_s1;

	logic is_dig, is_sign, is_e, take, take_frac, in_fire, ok_n;
	logic [3:0] dg;
	logic [35:0] ex36, exm36;

	logic signed [65:0] ex_w, fr_w, sh_w, q_w;

	always_comb begin
		is_dig = (char_code >= CH_0) && (char_code <= CH_9);
		is_sign = (char_code == CH_PLUS) || (char_code == CH_MINUS);
		is_e = (char_code == CH_E_UP) || (char_code == CH_E_LO);
		dg = is_dig ? char_code[3:0] : 4'd0;
		ex36 = {{(36-EXP_BITS){1'b0}}, exp_q};
		exm36 = (ex36 << 3) + (ex36 << 1) + {32'd0, dg};
		phase_n = phase_q;
		neg_n = neg_q;
		full_n = full_q;
		trunc_n = trunc_q;
		sig_n = sig_q;
		dcnt_n = dcnt_q;
		fcnt_n = fcnt_q;
		shift_n = shift_q;
		exp_n = exp_q;
		eneg_n = eneg_q;
		take = 1'b0;
		take_frac = 1'b0;
		if (has_char) begin
			case (phase_q)
				PH_START, PH_SIGN, PH_INT: begin
					if (is_dig) begin
						take = 1'b1;
						phase_n = PH_INT;
					end else if (phase_q == PH_START && is_sign) begin
						neg_n = (char_code == CH_MINUS);
						phase_n = PH_SIGN;
					end else if (char_code == CH_DOT) begin
						phase_n = PH_FRAC;
					end else if (is_e && dcnt_q != '0) begin
						phase_n = PH_EXP;
					end else begin
						phase_n = PH_BAD;
					end
				end
				PH_FRAC: begin
					if (is_dig) begin
						take = 1'b1;
						take_frac = 1'b1;
					end else if (is_e && dcnt_q != '0) begin
						phase_n = PH_EXP;
					end else begin
						phase_n = PH_BAD;
					end
				end
				PH_EXP, PH_EXPSIGN, PH_EXPDIG: begin
					if (is_dig) begin
						if (ex36 < EXP_LIMIT) begin
							exp_n = (|exm36[35:EXP_BITS]) ? '1 : exm36[EXP_BITS-1:0];
						end
						phase_n = PH_EXPDIG;
					end else if (phase_q == PH_EXP && is_sign) begin
						eneg_n = (char_code == CH_MINUS);
						phase_n = PH_EXPSIGN;
					end else begin
						phase_n = PH_BAD;
					end
				end
				default: begin
					phase_n = PH_BAD;
				end
			endcase
		end
		if (take) begin
			full_n = (full_q << 3) + (full_q << 1) + {60'd0, dg};
			dcnt_n = (dcnt_q != '1) ? dcnt_q + 1'b1 : dcnt_q;
			if (take_frac) begin
				fcnt_n = (fcnt_q != '1) ? fcnt_q + 1'b1 : fcnt_q;
			end
			if ((sig_q != 16'd0 || dg != 4'd0) && sig_q != SIG_MAX) begin
				sig_n = sig_q + 16'd1;
			end
			if (trunc_q < TRUNC_LIMIT) begin
				trunc_n = (trunc_q << 3) + (trunc_q << 1) + {60'd0, dg};
				if (take_frac && shift_q > SH_LOW) begin
					shift_n = shift_q - 1'b1;
				end
			end else if (!take_frac && shift_q < SH_MAX) begin
				shift_n = shift_q + 1'b1;
			end
		end
		ok_n = (phase_n == PH_INT || phase_n == PH_FRAC || phase_n == PH_EXPDIG) &&
			(dcnt_n != '0);
	end

	assign in_ready = !fin_v_s1 || rec_ready;
	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q <= 1'b0;
			full_q <= '0;
			trunc_q <= '0;
			sig_q <= '0;
			dcnt_q <= '0;
			fcnt_q <= '0;
			shift_q <= '0;
			exp_q <= '0;
			eneg_q <= 1'b0;
			fin_v_s1 <= 1'b0;
		end else begin
			if (in_fire) begin
				if (last_char) begin
					phase_q <= PH_START;
					neg_q <= 1'b0;
					full_q <= '0;
					trunc_q <= '0;
					sig_q <= '0;
					dcnt_q <= '0;
					fcnt_q <= '0;
					shift_q <= '0;
					exp_q <= '0;
					eneg_q <= 1'b0;
				end else begin
					phase_q <= phase_n;
					neg_q <= neg_n;
					full_q <= full_n;
					trunc_q <= trunc_n;
					sig_q <= sig_n;
					dcnt_q <= dcnt_n;
					fcnt_q <= fcnt_n;
					shift_q <= shift_n;
					exp_q <= exp_n;
					eneg_q <= eneg_n;
				end
			end
			if (in_fire && last_char) begin
				fin_v_s1 <= 1'b1;
			end else if (rec_ready) begin
				fin_v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && last_char) begin
			fin_ok_s1 <= ok_n;
			fin_neg_s1 <= neg_n;
			fin_too_s1 <= sig_n > SIG_KEEP;
			fin_w_s1 <= (sig_n > SIG_KEEP) ? trunc_n : full_n;
			fin_exp_s1 <= exp_n;
			fin_eneg_s1 <= eneg_n;
			fin_frac_s1 <= fcnt_n;
			fin_shift_s1 <= shift_n;
		end
	end

	// decimal exponent, saturated to the record's range
	always_comb begin
		ex_w = {{(66-EXP_BITS){1'b0}}, fin_exp_s1};
		if (fin_eneg_s1) begin
			ex_w = -ex_w;
		end
		fr_w = {{(66-CNT_BITS){1'b0}}, fin_frac_s1};
		if (fr_w > LIM_POS) begin
			fr_w = LIM_POS;
		end
		sh_w = {{(66-CNT_BITS){fin_shift_s1[CNT_BITS-1]}}, fin_shift_s1};
		if (sh_w > LIM_POS) begin
			sh_w = LIM_POS;
		end else if (sh_w < LIM_NEG) begin
			sh_w = LIM_NEG;
		end
		q_w = fin_too_s1 ? sh_w + ex_w : ex_w - fr_w;
		if (q_w > Q_HI) begin
			q_w = Q_HI;
		end else if (q_w < Q_LO) begin
			q_w = Q_LO;
		end
		rec.ok = fin_ok_s1;
		rec.neg = fin_neg_s1;
		rec.too = fin_too_s1;
		rec.w = fin_w_s1;
		rec.q = q_w[Q_BITS-1:0];
	end

	assign rec_valid = fin_v_s1;

endmodule

// File: design/dttf_fifo.sv
// ----------------------------------------------------------------------------
// dttf_fifo
// Two-entry record queue between the byte scanner and the converter.
// ----------------------------------------------------------------------------
module dttf_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  dttf_pkg::dttf_rec_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output dttf_pkg::dttf_rec_t pop_data
);
	import dttf_pkg::*;

	dttf_rec_t mem_q [0:1];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data = mem_q[rp_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

endmodule

// File: design/dttf_mul.sv
// ----------------------------------------------------------------------------
// dttf_mul
// 64x64 to 128-bit multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module dttf_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] prod
);
	logic [63:0] a_q, b_q;
	logic [63:0] pp_s1;
	logic [1:0] ppsh_s1;
	logic [2:0] cnt_q;
	logic busy_q, done_q;
	logic [127:0] acc_q;
	logic [31:0] op_a, op_b;
	logic [1:0] sh;
	logic [63:0] pp_c;
	logic [127:0] addend;

	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin
				op_a = a_q[31:0];
				op_b = b_q[31:0];
				sh = 2'd0;
			end
			2'd1: begin
				op_a = a_q[31:0];
				op_b = b_q[63:32];
				sh = 2'd1;
			end
			2'd2: begin
				op_a = a_q[63:32];
				op_b = b_q[31:0];
				sh = 2'd1;
			end
			default: begin
				op_a = a_q[63:32];
				op_b = b_q[63:32];
				sh = 2'd2;
			end
		endcase
		pp_c = op_a * op_b;
		addend = {64'd0, pp_s1} << {ppsh_s1, 5'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 3'd0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != 3'd4) begin
				pp_s1 <= pp_c;
				ppsh_s1 <= sh;
			end
			if (cnt_q != 3'd0) begin
				acc_q <= acc_q + addend;
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// File: design/dttf_conv.sv
// ----------------------------------------------------------------------------
// dttf_conv
// Converter: normalizes the mantissa, multiplies by the power-of-five table
// entry, rounds to the selected format and holds the result for transfer.
// ----------------------------------------------------------------------------
module dttf_conv (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                dbl,
	input  logic                rec_valid,
	output logic                rec_ready,
	input  dttf_pkg::dttf_rec_t rec,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [63:0]         value_bits,
	output logic [1:0]          status
);
	import dttf_pkg::*;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_CHK = 3'd1;
	localparam logic [2:0] B_NORM = 3'd2;
	localparam logic [2:0] B_MUL = 3'd3;
	localparam logic [2:0] B_MUL2 = 3'd4;
	localparam logic [2:0] B_RND1 = 3'd5;
	localparam logic [2:0] B_RND2 = 3'd6;
	localparam logic [2:0] B_FIN = 3'd7;

	localparam pow5_rom_t ROM = dttf_pow5_table();
	localparam logic signed [Q_BITS-1:0] IDX_OFS = 12'sd342;
	localparam logic signed [31:0] LOG2_10 = 32'sd217706;

	logic [2:0] state_q;
	logic neg_q, too_q, bad_q, pass_q;
	logic [63:0] wr_q, w_q, wn_q, hi_q, lo_q, m_q;
	logic signed [Q_BITS-1:0] q_q;
	logic [5:0] lz_q;
	logic signed [12:0] p2base_q, p2_q;
	logic [6:0] sh_q;
	logic [63:0] res_m_q, m0_q;
	logic [11:0] res_p_q, p0_q;
	logic [127:0] rom_q;
	logic out_v_q;
	logic [63:0] out_bits_q;
	logic [1:0] out_st_q;

	logic [5:0] f_mant, f_sign;
	logic [6:0] f_shbase;
	logic [63:0] f_mask;
	logic signed [12:0] f_min_exp;
	logic [11:0] f_inf;
	logic signed [Q_BITS-1:0] f_small, f_large, f_rte_lo, f_rte_hi;

	logic mul_start, mul_done;
	logic [63:0] mul_b;
	logic [127:0] mul_prod;
	logic [Q_BITS-1:0] idx_w;
	logic signed [31:0] p10;
	logic signed [31:0] p10_sh;
	logic [63:0] lo_sum;
	logic upper;
	logic signed [12:0] rs;
	logic [63:0] msub, mn, hid;
	logic signed [12:0] pn;
	logic [63:0] rnd_m;
	logic [11:0] rnd_p;
	logic fin_ready, mism;
	logic [63:0] word;

	always_comb begin
		if (dbl) begin
			f_mant = F64_MANT;
			f_sign = F64_SIGN;
			f_shbase = F64_SHBASE;
			f_mask = F64_MASK;
			f_min_exp = F64_MIN_EXP;
			f_inf = F64_INF;
			f_small = F64_SMALL10;
			f_large = F64_LARGE10;
			f_rte_lo = F64_RTE_LO;
			f_rte_hi = F64_RTE_HI;
		end else begin
			f_mant = F32_MANT;
			f_sign = F32_SIGN;
			f_shbase = F32_SHBASE;
			f_mask = F32_MASK;
			f_min_exp = F32_MIN_EXP;
			f_inf = F32_INF;
			f_small = F32_SMALL10;
			f_large = F32_LARGE10;
			f_rte_lo = F32_RTE_LO;
			f_rte_hi = F32_RTE_HI;
		end
	end

	assign idx_w = q_q + IDX_OFS;

	always_ff @(posedge clk) begin
		rom_q <= ROM[idx_w[POW5_IDX_BITS-1:0]];
	end

	assign mul_b = (state_q == B_NORM) ? rom_q[127:64] : rom_q[63:0];
	assign mul_start = (state_q == B_NORM && wn_q[63]) ||
		(state_q == B_MUL && mul_done && ((mul_prod[127:64] & f_mask) == f_mask));

	dttf_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(wn_q),
		.b(mul_b),
		.done(mul_done),
		.prod(mul_prod)
	);

	always_comb begin
		p10 = {{(32-Q_BITS){q_q[Q_BITS-1]}}, q_q} * LOG2_10;
		p10_sh = p10 >>> 16;
		lo_sum = lo_q + mul_prod[127:64];
		upper = hi_q[63];

		// final rounding
		rs = 13'sd1 - p2_q;
		msub = m_q >> rs[5:0];
		msub = msub + {63'd0, msub[0]};
		msub = msub >> 1;
		mn = m_q;
		hid = 64'd1 << f_mant;
		if (lo_q <= 64'd1 && q_q >= f_rte_lo && q_q <= f_rte_hi && mn[1:0] == 2'b01 &&
			(mn << sh_q) == hi_q) begin
			mn[0] = 1'b0;
		end
		mn = mn + {63'd0, mn[0]};
		mn = mn >> 1;
		pn = p2_q;
		if (mn >= (hid << 1)) begin
			mn = hid;
			pn = pn + 13'sd1;
		end
		mn = mn & ~hid;
		if (pn >= $signed({1'b0, f_inf})) begin
			pn = $signed({1'b0, f_inf});
			mn = 64'd0;
		end
		if (p2_q <= 13'sd0) begin
			if (rs >= 13'sd64) begin
				rnd_m = 64'd0;
				rnd_p = 12'd0;
			end else begin
				rnd_m = msub;
				rnd_p = (msub < hid) ? 12'd0 : 12'd1;
			end
		end else begin
			rnd_m = mn;
			rnd_p = pn[11:0];
		end

		fin_ready = !out_v_q || out_ready;
		mism = pass_q && (res_m_q != m0_q || res_p_q != p0_q);
		word = res_m_q | ({52'd0, res_p_q} << f_mant) | ({63'd0, neg_q} << f_sign);
		if (!dbl) begin
			word[63:32] = 32'd0;
		end
	end

	assign rec_ready = (state_q == B_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (rec_valid) begin
						state_q <= rec.ok ? B_CHK : B_FIN;
					end
				end
				B_CHK: begin
					if (w_q == 64'd0 || q_q < f_small || q_q > f_large) begin
						state_q <= B_FIN;
					end else begin
						state_q <= B_NORM;
					end
				end
				B_NORM: begin
					if (wn_q[63]) begin
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					if (mul_done) begin
						state_q <= mul_start ? B_MUL2 : B_RND1;
					end
				end
				B_MUL2: begin
					if (mul_done) begin
						state_q <= B_RND1;
					end
				end
				B_RND1: begin
					state_q <= B_RND2;
				end
				B_RND2: begin
					state_q <= B_FIN;
				end
				B_FIN: begin
					if (!bad_q && !pass_q && too_q) begin
						state_q <= B_CHK;
					end else if (fin_ready) begin
						out_v_q <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				neg_q <= rec.neg;
				too_q <= rec.too;
				bad_q <= !rec.ok;
				wr_q <= rec.w;
				w_q <= rec.w;
				q_q <= rec.q;
				pass_q <= 1'b0;
			end
			B_CHK: begin
				wn_q <= w_q;
				lz_q <= 6'd0;
				p2base_q <= p10_sh[12:0] + 13'sd63 - f_min_exp;
				res_m_q <= 64'd0;
				res_p_q <= (w_q != 64'd0 && q_q > f_large) ? f_inf : 12'd0;
			end
			B_NORM: begin
				if (!wn_q[63]) begin
					if (wn_q[63:56] == 8'd0) begin
						wn_q <= wn_q << 8;
						lz_q <= lz_q + 6'd8;
					end else begin
						wn_q <= wn_q << 1;
						lz_q <= lz_q + 6'd1;
					end
				end
			end
			B_MUL: begin
				if (mul_done) begin
					hi_q <= mul_prod[127:64];
					lo_q <= mul_prod[63:0];
				end
			end
			B_MUL2: begin
				if (mul_done) begin
					lo_q <= lo_sum;
					if (lo_sum < mul_prod[127:64]) begin
						hi_q <= hi_q + 64'd1;
					end
				end
			end
			B_RND1: begin
				sh_q <= f_shbase + {6'd0, upper};
				m_q <= hi_q >> (f_shbase + {6'd0, upper});
				p2_q <= p2base_q + $signed({12'd0, upper}) - $signed({7'd0, lz_q});
			end
			B_RND2: begin
				res_m_q <= rnd_m;
				res_p_q <= rnd_p;
			end
			B_FIN: begin
				if (!bad_q && !pass_q && too_q) begin
					m0_q <= res_m_q;
					p0_q <= res_p_q;
					pass_q <= 1'b1;
					w_q <= wr_q + 64'd1;
				end else if (fin_ready) begin
					if (bad_q) begin
						out_st_q <= ST_MALFORMED;
						out_bits_q <= 64'd0;
					end else if (mism) begin
						out_st_q <= ST_AMBIGUOUS;
						out_bits_q <= 64'd0;
					end else begin
						out_st_q <= ST_OK;
						out_bits_q <= word;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_v_q;
	assign value_bits = out_bits_q;
	assign status = out_st_q;

endmodule

// File: design/decimal_text_to_ieee754_float.sv
// ----------------------------------------------------------------------------
// decimal_text_to_ieee754_float
// Streams decimal text fields and returns correctly rounded IEEE binary
// patterns (single or double), with status for malformed or ambiguous input.
// ----------------------------------------------------------------------------
// Usage
// - input channel: at most one byte per transfer (char_code, has_char, last_char);
//   the scanner takes a byte every cycle while in_ready is high, last_char closes the field
// - output channel: one transfer per field (value_bits, status), held in a
//   register until taken; a stalled receiver backs up the converter, the
//   two-entry record queue and the scanner's record register, then in_ready
//   drops
// - path from the last byte to out_valid: scanner record register, record
//   queue, converter; malformed text skips the conversion, a zero or
//   out-of-range value skips the normalizer and the multiplier, else both
//   run (the 64x64 multiplier from 32x32 parts, one or two products); fields
//   with more than 19 significant digits take a second pass
// - throughput: one byte per cycle while the converter keeps up with fields
// - APB register 0 (bit 0): double_format, 1 after reset; the user writes it
//   only idle, unenforced; reset clears the parser, the queue and the output valid
// ----------------------------------------------------------------------------
module decimal_text_to_ieee754_float #(
	parameter int EXPONENT_COUNTER_BITS = dttf_pkg::CNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        has_char,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] value_bits,
	output logic [1:0]  status
);
	import dttf_pkg::*;

	localparam logic REG_DOUBLE = 1'b0;

	logic dbl_q;
	dttf_rec_t scan_rec, conv_rec;
	logic scan_v, scan_r, conv_v, conv_r;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DOUBLE) ? {31'd0, dbl_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbl_q <= 1'b1;
		end else if (psel && penable && pwrite && paddr[2] == REG_DOUBLE) begin
			dbl_q <= pwdata[0];
		end
	end

	dttf_scan #(
		.CNT_BITS(EXPONENT_COUNTER_BITS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.has_char(has_char),
		.last_char(last_char),
		.rec_valid(scan_v),
		.rec_ready(scan_r),
		.rec(scan_rec)
	);

	dttf_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(scan_v),
		.push_ready(scan_r),
		.push_data(scan_rec),
		.pop_valid(conv_v),
		.pop_ready(conv_r),
		.pop_data(conv_rec)
	);

	dttf_conv u_conv (
		.clk(clk),
		.arst_n(arst_n),
		.dbl(dbl_q),
		.rec_valid(conv_v),
		.rec_ready(conv_r),
		.rec(conv_rec),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value_bits(value_bits),
		.status(status)
	);

`ifndef SYNTHESIS
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_MALFORMED || status == ST_AMBIGUOUS))
		else $error("undefined status code");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (value_bits == 64'd0))
		else $error("nonzero value on error status");

	a_single_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !dbl_q) |-> (value_bits[63:32] == 32'd0))
		else $error("single result has upper bits set");
`endif

endmodule

// File: tb/sv/dttf_checker.sv
// ----------------------------------------------------------------------------
// dttf_checker
// Watches the register port and both data channels of the decimal text to
// float converter, predicts each conversion result and compares the results.
// ----------------------------------------------------------------------------
module dttf_checker #(
	parameter int CNT_BITS = 32,
	parameter logic [2:0] FMT_ADDR = 3'd0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        has_char,
	input  logic        last_char,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] value_bits,
	input  logic [1:0]  status,
	output int          errors,
	output int          pending,
	output int          results_seen
);

	typedef enum logic [2:0] {
		SCAN_START, SCAN_SIGN, SCAN_INT, SCAN_FRAC,
		SCAN_EXP, SCAN_EXPSIGN, SCAN_EXPDIG, SCAN_BAD
	} scan_t;

	typedef struct {
		logic [63:0] bits;
		logic [1:0]  code;
	} conv_t;

	localparam longint unsigned CNT_MAX = (64'd1 << CNT_BITS) - 64'd1;
	localparam longint SHIFT_MAX = longint'(CNT_MAX >> 1);
	localparam longint CLAMP = 64'sd1 << 60;

	logic [63:0] p5_hi [0:650];
	logic [63:0] p5_lo [0:650];

	conv_t conv_q [$];
	logic fmt_double;

	scan_t phase;
	logic sign_neg, exp_neg;
	logic [63:0] full_mant, trunc_mant;
	logic [15:0] sig_digits;
	longint unsigned digits, frac_digits, exp_value;
	longint drop_shift;

	function automatic int msb_of(input logic [2047:0] v);
		for (int i = 2047; i >= 0; i--) begin
			if (v[i]) return i;
		end
		return -1;
	endfunction

	task automatic keep_top(input logic [2047:0] v, input int idx);
		int t;
		t = msb_of(v);
		if (t >= 127) v = v >> (t - 127);
		else v = v << (127 - t);
		p5_hi[idx] = v[127:64];
		p5_lo[idx] = v[63:0];
	endtask

	task automatic build_pow5();
		logic [2047:0] pw;
		logic [2047:0] d;
		logic [2047:0] quo;
		int z;
		int b;
		pw = 2048'd1;
		for (int q = 0; q <= 308; q++) begin
			keep_top(pw, q + 342);
			pw = pw * 2048'd5;
		end
		d = 2048'd1;
		for (int k = 1; k <= 342; k++) begin
			d = d * 2048'd5;
			z = msb_of(d) + 1;
			b = (k <= 27) ? z + 127 : 2 * z + 128;
			quo = ((2048'd1) << b) / d + 2048'd1;
			keep_top(quo, 342 - k);
		end
	endtask

	function automatic int ten_to_two(input longint q);
		longint v;
		v = 64'sd217706 * q;
		return int'(v >>> 16) + 63;
	endfunction

	// rounded mantissa and biased exponent of w * 10^q
	function automatic logic [63:0] round_value(input logic dbl, input longint q,
			input logic [63:0] w, output int pw2);
		int mw, min_exp, inf, lz, upper, shift, p2;
		longint small10, large10, rte_lo, rte_hi;
		logic [127:0] prod, prod2;
		logic [63:0] hi, lo, m, mask;
		mw = dbl ? 52 : 23;
		min_exp = dbl ? -1023 : -127;
		inf = dbl ? 'h7FF : 'hFF;
		small10 = dbl ? -342 : -64;
		large10 = dbl ? 308 : 38;
		rte_lo = dbl ? -4 : -17;
		rte_hi = dbl ? 23 : 10;
		pw2 = 0;
		if (w == 0 || q < small10) return 64'd0;
		if (q > large10) begin
			pw2 = inf;
			return 64'd0;
		end
		lz = 0;
		while (!w[63]) begin
			w = w << 1;
			lz++;
		end
		prod = {64'd0, w} * {64'd0, p5_hi[q + 342]};
		hi = prod[127:64];
		lo = prod[63:0];
		mask = 64'hFFFF_FFFF_FFFF_FFFF >> (mw + 3);
		if ((hi & mask) == mask) begin
			prod2 = {64'd0, w} * {64'd0, p5_lo[q + 342]};
			lo = lo + prod2[127:64];
			if (prod2[127:64] > lo) hi = hi + 64'd1;
		end
		upper = hi[63];
		shift = upper + 61 - mw;
		m = hi >> shift;
		p2 = ten_to_two(q) + upper - lz - min_exp;
		if (p2 <= 0) begin
			if (-p2 + 1 >= 64) return 64'd0;
			m = m >> (-p2 + 1);
			m = m + m[0];
			m = m >> 1;
			pw2 = (m < (64'd1 << mw)) ? 0 : 1;
			return m;
		end
		if (lo <= 1 && q >= rte_lo && q <= rte_hi && m[1:0] == 2'b01) begin
			if ((m << shift) == hi) m[0] = 1'b0;
		end
		m = m + m[0];
		m = m >> 1;
		if (m >= (64'd2 << mw)) begin
			m = 64'd1 << mw;
			p2++;
		end
		m = m & ~(64'd1 << mw);
		if (p2 >= inf) begin
			p2 = inf;
			m = 64'd0;
		end
		pw2 = p2;
		return m;
	endfunction

	function automatic longint clamp_cnt(input longint unsigned v);
		return (v > 64'd1 << 60) ? CLAMP : longint'(v);
	endfunction

	function automatic longint unsigned sat_inc(input longint unsigned v);
		return (v < CNT_MAX) ? v + 64'd1 : CNT_MAX;
	endfunction

	task automatic clear_field();
		phase = SCAN_START;
		sign_neg = 1'b0;
		exp_neg = 1'b0;
		full_mant = '0;
		trunc_mant = '0;
		sig_digits = '0;
		digits = 0;
		frac_digits = 0;
		exp_value = 0;
		drop_shift = 0;
	endtask

	task automatic take_digit(input logic [3:0] dg, input logic frac);
		full_mant = full_mant * 64'd10 + dg;
		digits = sat_inc(digits);
		if (frac) frac_digits = sat_inc(frac_digits);
		if ((sig_digits > 0 || dg != 0) && sig_digits < 16'hFFFF) sig_digits++;
		if (trunc_mant < 64'd1000000000000000000) begin
			trunc_mant = trunc_mant * 64'd10 + dg;
			if (frac && drop_shift > -SHIFT_MAX) drop_shift--;
		end else if (!frac && drop_shift < SHIFT_MAX) begin
			drop_shift++;
		end
	endtask

	task automatic scan_byte(input logic [7:0] c);
		logic is_dig;
		logic [3:0] dg;
		logic is_e;
		logic is_sgn;
		is_dig = (c >= "0" && c <= "9");
		dg = is_dig ? 4'(c - "0") : 4'd0;
		is_e = (c == "e" || c == "E");
		is_sgn = (c == "-" || c == "+");
		case (phase)
			SCAN_START, SCAN_SIGN, SCAN_INT: begin
				if (is_dig) begin
					take_digit(dg, 1'b0);
					phase = SCAN_INT;
				end else if (phase == SCAN_START && is_sgn) begin
					sign_neg = (c == "-");
					phase = SCAN_SIGN;
				end else if (c == ".") phase = SCAN_FRAC;
				else if (is_e && digits > 0) phase = SCAN_EXP;
				else phase = SCAN_BAD;
			end
			SCAN_FRAC: begin
				if (is_dig) take_digit(dg, 1'b1);
				else if (is_e && digits > 0) phase = SCAN_EXP;
				else phase = SCAN_BAD;
			end
			SCAN_EXP, SCAN_EXPSIGN, SCAN_EXPDIG: begin
				if (is_dig) begin
					if (exp_value < 64'h1000_0000) begin
						exp_value = exp_value * 10 + dg;
						if (exp_value > CNT_MAX) exp_value = CNT_MAX;
					end
					phase = SCAN_EXPDIG;
				end else if (phase == SCAN_EXP && is_sgn) begin
					exp_neg = (c == "-");
					phase = SCAN_EXPSIGN;
				end else phase = SCAN_BAD;
			end
			default: phase = SCAN_BAD;
		endcase
	endtask

	function automatic conv_t convert_field();
		conv_t r;
		longint ex, q, s;
		logic [63:0] w, m, m2;
		int p2, p22, mw;
		logic too;
		r.bits = '0;
		r.code = dttf_pkg::ST_OK;
		mw = fmt_double ? 52 : 23;
		if (!((phase == SCAN_INT || phase == SCAN_FRAC || phase == SCAN_EXPDIG)
				&& digits > 0)) begin
			r.code = dttf_pkg::ST_MALFORMED;
			return r;
		end
		ex = clamp_cnt(exp_value);
		if (exp_neg) ex = -ex;
		too = sig_digits > 19;
		if (too) begin
			s = drop_shift;
			if (s > CLAMP) s = CLAMP;
			if (s < -CLAMP) s = -CLAMP;
			w = trunc_mant;
			q = s + ex;
		end else begin
			w = full_mant;
			q = ex - clamp_cnt(frac_digits);
		end
		m = round_value(fmt_double, q, w, p2);
		if (too) begin
			m2 = round_value(fmt_double, q, w + 64'd1, p22);
			if (m2 != m || p22 != p2) begin
				r.code = dttf_pkg::ST_AMBIGUOUS;
				return r;
			end
		end
		r.bits = m | (64'(unsigned'(p2)) << mw) | (64'(sign_neg) << (fmt_double ? 63 : 31));
		if (!fmt_double) r.bits[63:32] = '0;
		return r;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %h, expected %h", what, got, want);
	endtask

	initial begin
		errors = 0;
		pending = 0;
		results_seen = 0;
		fmt_double = 1'b1;
		clear_field();
		build_pow5();
	end

	always @(posedge clk) begin
		conv_t want;
		if (!arst_n) begin
			fmt_double = 1'b1;
			clear_field();
			conv_q.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == FMT_ADDR)
				fmt_double = pwdata[0];
			if (in_valid && in_ready) begin
				if (has_char) scan_byte(char_code);
				if (last_char) begin
					conv_q.push_back(convert_field());
					clear_field();
				end
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (conv_q.size() == 0) begin
					report("unexpected transfer", value_bits, 64'd0);
				end else begin
					want = conv_q.pop_front();
					if (status !== want.code) report("status", 64'(status), 64'(want.code));
					if (value_bits !== want.bits) report("value_bits", value_bits, want.bits);
				end
			end
		end
		pending = conv_q.size();
	end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives text fields byte by byte into the decimal text to float converter in
// both formats, directed corner values first and then random fields, with
// random gaps and stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [2:0] REG_DOUBLE_FORMAT = 3'd0;
	localparam int LIMIT = 300000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] char_code = '0;
	logic has_char = 1'b0;
	logic last_char = 1'b0;
	logic out_valid;
	logic out_ready = 1'b1;
	logic [63:0] value_bits;
	logic [1:0] status;

	int errors, pending, results_seen;
	int cycles = 0;
	int bytes_sent = 0;
	int fields_sent = 0;
	int rx_wait = 0;
	bit idle_on = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	decimal_text_to_ieee754_float i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.char_code(char_code), .has_char(has_char), .last_char(last_char),
		.out_valid(out_valid), .out_ready(out_ready),
		.value_bits(value_bits), .status(status)
	);

	dttf_checker #(.FMT_ADDR(REG_DOUBLE_FORMAT)) i_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.char_code(char_code), .has_char(has_char), .last_char(last_char),
		.out_valid(out_valid), .out_ready(out_ready),
		.value_bits(value_bits), .status(status),
		.errors(errors), .pending(pending), .results_seen(results_seen)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("decimal_text_to_ieee754_float test failed");
			$finish;
		end
	end

	// receiver may stall after each transfer while idle_on is set
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			rx_wait = idle_on ? $urandom_range(0, 13) : 0;
			out_ready <= (rx_wait == 0);
		end else if (rx_wait > 0) begin
			rx_wait--;
			out_ready <= (rx_wait == 0);
		end
	end

	task automatic send_item(input logic [7:0] c, input logic h, input logic l);
		int gap;
		gap = idle_on ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		has_char <= h;
		last_char <= l;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		if (h) bytes_sent++;
	endtask

	task automatic send_field(input byte unsigned f[$], input bit empty_tail);
		fields_sent++;
		if (f.size() == 0) empty_tail = 1'b1;
		for (int i = 0; i < f.size(); i++) begin
			if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(f[i], 1'b1, !empty_tail && i == f.size() - 1);
		end
		if (empty_tail) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	task automatic send_text(input string s);
		byte unsigned f[$];
		for (int i = 0; i < s.len(); i++) f.push_back(s[i]);
		send_field(f, 1'b0);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_format(input logic v);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_DOUBLE_FORMAT;
		pwdata <= {31'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic add_digits(ref byte unsigned f[$], input int n);
		for (int i = 0; i < n; i++) f.push_back(8'("0" + $urandom_range(0, 9)));
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return $urandom_range(0, 6);
		if (r < 9) return $urandom_range(7, 19);
		return $urandom_range(20, 28);
	endfunction

	task automatic send_random_field();
		byte unsigned f[$];
		string noise_set;
		int n, kind, ev;
		noise_set = "0123456789.+-eE";
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			case ($urandom_range(0, 2))
				0: f.push_back("-");
				1: if ($urandom_range(0, 1)) f.push_back("+");
				default: ;
			endcase
			if ($urandom_range(0, 7) == 0) add_digits(f, 0);
			if ($urandom_range(0, 7) == 0) f.push_back("0");
			n = pick_len();
			add_digits(f, n);
			if ($urandom_range(0, 1)) begin
				f.push_back(".");
				add_digits(f, pick_len());
			end
			if (f.size() == 0 || f[f.size() - 1] < "0" || f[f.size() - 1] > "9")
				add_digits(f, 1);
			if ($urandom_range(0, 1)) begin
				f.push_back($urandom_range(0, 1) ? "e" : "E");
				case ($urandom_range(0, 2))
					0: f.push_back("-");
					1: f.push_back("+");
					default: ;
				endcase
				if ($urandom_range(0, 19) == 0) begin
					add_digits(f, $urandom_range(10, 14));
				end else begin
					ev = $urandom_range(0, 1) ? $urandom_range(0, 60) : $urandom_range(0, 360);
					if (ev >= 100) f.push_back(8'("0" + ev / 100));
					if (ev >= 10) f.push_back(8'("0" + (ev / 10) % 10));
					f.push_back(8'("0" + ev % 10));
				end
			end
			if (kind >= 80) f[$urandom_range(0, f.size() - 1)] = 8'($urandom_range(0, 255));
		end else begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				f.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
					: noise_set[$urandom_range(0, noise_set.len() - 1)]);
		end
		send_field(f, $urandom_range(0, 9) == 0);
	endtask

	task automatic send_corners();
		byte unsigned f[$];
		send_text("0");
		send_text("-0");
		send_text("+1");
		send_text("1.5");
		send_text("3.4028235e38");
		send_text("1.7976931348623157e308");
		send_text("2.2250738585072014e-308");
		send_text("4.9e-324");
		send_text("1.4e-45");
		send_text("1e-400");
		send_text("-1E+400");
		send_text("12345678901234567890123");
		send_text("9007199254740993");
		send_text(".5");
		send_text("5.");
		send_text("e5");
		send_text("1e");
		send_text("1e+");
		send_text("+");
		send_text("1x");
		f.delete();
		f.push_back(8'h37);
		f.push_back(8'hFF);
		send_field(f, 1'b0);
		send_text("1e99999999999");
		f.delete();
		send_field(f, 1'b1);
		f.push_back(8'h32);
		f.push_back(8'h35);
		send_field(f, 1'b1);
	endtask

	initial begin
		logic fmt;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < 4; ph++) begin
			fmt = (ph % 2 == 0);
			write_format(fmt);
			if (ph < 2) send_corners();
			while (bytes_sent < (ph + 1) * 115) begin
				if ($urandom_range(0, 4) == 0) idle_on = ~idle_on;
				send_random_field();
			end
		end
		drain();
		repeat (20) @(posedge clk);
		$display("sent %0d bytes in %0d fields over both formats, %0d results checked",
			bytes_sent, fields_sent, results_seen);
		if (errors == 0) begin
			$display("decimal_text_to_ieee754_float test passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("decimal_text_to_ieee754_float test failed");
		end
		$finish;
	end

endmodule

// File: decimal_text_to_ieee754_float.f
design/dttf_pkg.sv
design/dttf_scan.sv
design/dttf_fifo.sv
design/dttf_mul.sv
design/dttf_conv.sv
design/decimal_text_to_ieee754_float.sv
tb/sv/dttf_checker.sv
tb/sv/tb.sv
